/* rtl/core/mpt_pkg.sv */
// Shared constants and types of the multiclass perceptron trainer.
package mpt_pkg;

    localparam int DEF_NEURONS     = 6;
    localparam int DEF_INPUTS      = 31;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam int PIXEL_BITS  = 30;
    localparam int TARGET_BITS = 3;
    localparam int MASK_BITS   = 6;
    localparam int COUNT_BITS  = 3;

    // Step controls broadcast from the sequencer to every neuron.
    typedef struct packed {
        logic clear;   // zero the accumulator before a new item
        logic step;    // rotate the weight line by one position
        logic update;  // rotation rewrites corrected weights
    } mpt_ctl_t;

endpackage

/* rtl/core/multiclass_perceptron_trainer.sv */
// Top level of the multiclass perceptron trainer: sequencer, input line and result register.
//
// The block trains NEURONS one-versus-rest perceptrons. Each input item on the
// in channel (in_valid, in_stall, pixels, target_class) carries one binary
// pattern and the index of the class it belongs to; a bias input of 1 is
// prepended inside the block. Each item yields exactly one result item on the
// out channel (out_valid, out_stall, fired_mask, error_count): the neurons that
// fired before the update and the number of neurons that were corrected.
// An item is accepted when valid is high and stall is low at a clock edge.
// The weights of every neuron sit in a rotating line and are visited one per
// cycle, all neurons side by side. An item is accumulated over one rotation
// of the line (ST_SUM), has its weights rewritten over a second rotation
// (ST_UPDATE) and posts its result from ST_DONE once the result register is
// free; the block takes no new item until it is back in ST_IDLE.
// The result register lets the next item be accepted and processed while an
// earlier result is still stalled; a finished item then waits until the
// result register is free. Reset clears all weights to zero at once and
// leaves the block idle with no result pending.
module multiclass_perceptron_trainer
    import mpt_pkg::*;
#(
    parameter int NEURONS     = DEF_NEURONS,
    parameter int INPUTS      = DEF_INPUTS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIXEL_BITS-1:0]  pixels,
    input  logic [TARGET_BITS-1:0] target_class,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MASK_BITS-1:0]   fired_mask,
    output logic [COUNT_BITS-1:0]  error_count
);

    localparam int IDX_BITS = $clog2(INPUTS);
    localparam int CNT_BITS = $clog2(NEURONS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [INPUTS-1:0]      x_reg;
    logic [INPUTS-1:0]      x_load;
    logic [TARGET_BITS-1:0] target_reg;
    logic                   out_valid_reg;
    logic [MASK_BITS-1:0]   mask_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    mpt_ctl_t               ctl;
    logic [NEURONS-1:0]     is_target;
    logic [NEURONS-1:0]     fire;
    logic [NEURONS-1:0]     correct;
    logic [MASK_BITS-1:0]   mask_next;
    logic [CNT_BITS-1:0]    count_next;
    logic                   accept;
    logic                   last_idx;
    logic                   out_free;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign last_idx    = (idx_reg == IDX_BITS'(INPUTS - 1));
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign fired_mask  = mask_reg;
    assign error_count = count_reg;

    // Input vector: bias first, then the pixels; inputs past the field read as zero.
    generate
        for (genvar j = 0; j < INPUTS; j++)
        begin : g_xload
            if (j == 0)
            begin : g_bias
                assign x_load[j] = 1'b1;
            end
            else if (j - 1 < PIXEL_BITS)
            begin : g_pix
                assign x_load[j] = pixels[j-1];
            end
            else
            begin : g_zero
                assign x_load[j] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        ctl.clear  = accept;
        ctl.step   = (state_reg == ST_SUM) || (state_reg == ST_UPDATE);
        ctl.update = (state_reg == ST_UPDATE);
    end

    generate
        for (genvar n = 0; n < NEURONS; n++)
        begin : g_neuron
            assign is_target[n] = (32'(target_reg) == n);

            mpt_neuron #(
                .INPUTS      (INPUTS),
                .WEIGHT_BITS (WEIGHT_BITS)
            ) u_neuron (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .x         (x_reg[0]),
                .is_target (is_target[n]),
                .fire      (fire[n]),
                .correct   (correct[n])
            );
        end

        for (genvar b = 0; b < MASK_BITS; b++)
        begin : g_mask
            if (b < NEURONS)
            begin : g_used
                assign mask_next[b] = fire[b];
            end
            else
            begin : g_pad
                assign mask_next[b] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        count_next = '0;
        for (int n = 0; n < NEURONS; n++)
        begin
            count_next = count_next + CNT_BITS'(correct[n]);
        end
    end

    // Sequencer: the input line rotates once while summing and once while
    // rewriting, so both passes see the inputs in the same order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the done state the result register is handled below.
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_BITS'(1);
                    end
                end
                ST_UPDATE:
                begin
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_BITS'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= x_load;
            target_reg <= target_class;
        end
        else if (ctl.step)
        begin
            x_reg <= {x_reg[0], x_reg[INPUTS-1:1]};
        end

        // The fired mask reflects the sums before the update; the accumulators hold
        // their sums through the rewrite, so the figures are still valid here.
        if ((state_reg == ST_DONE) && out_free)
        begin
            mask_reg  <= mask_next;
            count_reg <= COUNT_BITS'(count_next);
        end
    end

endmodule

/* rtl/core/mpt_neuron.sv */
// One perceptron: a rotating weight line, a serial accumulator and a saturating update.
module mpt_neuron
    import mpt_pkg::*;
#(
    parameter int INPUTS      = DEF_INPUTS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mpt_ctl_t ctl,
    input  logic     x,
    input  logic     is_target,
    output logic     fire,
    output logic     correct
);

    localparam int ACC_BITS = WEIGHT_BITS + $clog2(INPUTS) + 1;
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    logic signed [WEIGHT_BITS-1:0] w_reg [INPUTS];
    logic signed [WEIGHT_BITS-1:0] head;
    logic signed [WEIGHT_BITS-1:0] tail_next;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [ACC_BITS-1:0]    acc_next;

    assign head    = w_reg[0];
    assign fire    = !acc_reg[ACC_BITS-1] && (acc_reg != '0);
    assign correct = is_target ? !fire : fire;

    // The weight at the head re-enters at the tail, corrected when needed.
    always_comb
    begin
        tail_next = head;
        if (ctl.update && correct && x)
        begin
            if (is_target)
            begin
                tail_next = (head == W_MAX) ? head : head + WEIGHT_BITS'(1);
            end
            else
            begin
                tail_next = (head == W_MIN) ? head : head - WEIGHT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.step && !ctl.update && x)
        begin
            acc_next = acc_reg + ACC_BITS'(head);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < INPUTS; k++)
            begin
                w_reg[k] <= '0;
            end
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (ctl.step)
            begin
                for (int k = 0; k < INPUTS - 1; k++)
                begin
                    w_reg[k] <= w_reg[k+1];
                end
                w_reg[INPUTS-1] <= tail_next;
            end
        end
    end

endmodule

/* tb/mpt_checker.sv */
// Checker of the multiclass perceptron trainer: predicts each result and compares it.
module mpt_checker
    import mpt_pkg::*;
#(
    parameter int NEURONS     = DEF_NEURONS,
    parameter int INPUTS      = DEF_INPUTS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [PIXEL_BITS-1:0]  pixels,
    input  logic [TARGET_BITS-1:0] target_class,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [MASK_BITS-1:0]   fired_mask,
    input  logic [COUNT_BITS-1:0]  error_count,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MASK_BITS-1:0]  mask;
        logic [COUNT_BITS-1:0] count;
    } outcome_t;

    localparam longint W_MAX = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;

    logic signed [WEIGHT_BITS-1:0] weight_mem [NEURONS][INPUTS];
    outcome_t                      outcomes_due [$];
    int                            mismatches;

    function automatic longint pixel_in(input logic [PIXEL_BITS-1:0] pix, input int j);
        if (j == 0)
            return 1;
        if (j - 1 < PIXEL_BITS)
            return longint'(pix[j-1]);
        return 0;
    endfunction

    function automatic logic signed [WEIGHT_BITS-1:0] clamp_weight(input longint v);
        if (v > W_MAX)
            return W_MAX[WEIGHT_BITS-1:0];
        if (v < W_MIN)
            return W_MIN[WEIGHT_BITS-1:0];
        return v[WEIGHT_BITS-1:0];
    endfunction

    // One training step on every neuron; the sums are all taken from the old weights
    // of that neuron, which is all that matters since neurons never share weights.
    function automatic outcome_t train_on_pattern(input logic [PIXEL_BITS-1:0] pix,
                                                  input logic [TARGET_BITS-1:0] tgt);
        outcome_t res;
        longint   sum;
        longint   delta;
        logic     fire;
        int       corrected;
        logic [63:0] mask;
        mask = '0;
        corrected = 0;
        for (int n = 0; n < NEURONS; n++) begin
            sum = 0;
            for (int j = 0; j < INPUTS; j++)
                sum += longint'(weight_mem[n][j]) * pixel_in(pix, j);
            fire = (sum >= 1);
            mask[n] = fire;
            delta = 0;
            if (n == int'(tgt)) begin
                if (!fire)
                    delta = 1;
            end else if (fire) begin
                delta = -1;
            end
            if (delta != 0) begin
                corrected++;
                for (int j = 0; j < INPUTS; j++)
                    weight_mem[n][j] = clamp_weight(longint'(weight_mem[n][j])
                                                    + delta * pixel_in(pix, j));
            end
        end
        res.mask  = mask[MASK_BITS-1:0];
        res.count = corrected[COUNT_BITS-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        if (!rst_n) begin
            for (int n = 0; n < NEURONS; n++)
                for (int j = 0; j < INPUTS; j++)
                    weight_mem[n][j] = '0;
            outcomes_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            // A result leaving at this edge always belongs to an older item.
            if (out_valid && !out_stall) begin
                if (outcomes_due.size() == 0) begin
                    $error("result with no item waiting: fired_mask %0h error_count %0d",
                           fired_mask, error_count);
                    mismatches++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (fired_mask !== want.mask) begin
                        $error("fired_mask: expected %0h, actual %0h", want.mask, fired_mask);
                        mismatches++;
                    end
                    if (error_count !== want.count) begin
                        $error("error_count: expected %0d, actual %0d",
                               want.count, error_count);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                outcomes_due.push_back(train_on_pattern(pixels, target_class));
            fail_count <= mismatches;
            pending    <= outcomes_due.size();
        end
    end

endmodule

/* tb/multiclass_perceptron_trainer_tb.sv */
// Testbench top of the multiclass perceptron trainer: clock, reset, stimulus and verdict.
module multiclass_perceptron_trainer_tb
    import mpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1400;
    localparam int STEADY_ITEMS = 150;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIXEL_BITS-1:0]  pixels;
    logic [TARGET_BITS-1:0] target_class;
    logic                   out_valid;
    logic                   out_stall;
    logic [MASK_BITS-1:0]   fired_mask;
    logic [COUNT_BITS-1:0]  error_count;
    int                     fail_count;
    int                     pending;

    // While steady is set, neither side idles, so the block runs at its full rate.
    bit                     steady;

    // One prototype pattern per class, as a host would train on a fixed letter set.
    logic [PIXEL_BITS-1:0]  prototype [DEF_NEURONS];

    multiclass_perceptron_trainer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixels       (pixels),
        .target_class (target_class),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fired_mask   (fired_mask),
        .error_count  (error_count)
    );

    mpt_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixels       (pixels),
        .target_class (target_class),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fired_mask   (fired_mask),
        .error_count  (error_count),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver stalls about a quarter of the time, except in the steady stretch.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            out_stall <= steady ? 1'b0 : ($urandom_range(99) < 25);
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("multiclass_perceptron_trainer test failed");
        $finish;
    end

    // Offers one item, idling first at random, and returns at the edge that accepts it.
    // The valid is left high, so a following item keeps the channel busy without a gap.
    task automatic offer_pattern(input logic [PIXEL_BITS-1:0] pix,
                                 input logic [TARGET_BITS-1:0] tgt);
        if (!steady) begin
            while ($urandom_range(99) < 25) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        pixels       <= pix;
        target_class <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drops the valid and waits until every result owed by the block has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // A prototype with a few pixels flipped, which is how noisy training data looks.
    function automatic logic [PIXEL_BITS-1:0] noisy_copy(input int cls);
        logic [PIXEL_BITS-1:0] pix;
        int flips;
        pix = prototype[cls];
        flips = $urandom_range(3);
        for (int f = 0; f < flips; f++)
            pix[$urandom_range(PIXEL_BITS-1)] ^= 1'b1;
        return pix;
    endfunction

    initial begin
        int pick;
        int cls;
        logic [PIXEL_BITS-1:0] pix;
        logic [TARGET_BITS-1:0] tgt;

        steady       = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        pixels       <= '0;
        target_class <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty pattern only reaches the bias weight; the all-ones
        // pattern reaches every weight. Targets six and seven name no neuron, so those
        // items can only weaken neurons that fire.
        offer_pattern('0, 3'd0);
        offer_pattern('0, 3'd0);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd1);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd2);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd6);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd7);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd3);
        offer_pattern(30'h0000_0001, 3'd4);
        offer_pattern(30'h2000_0000, 3'd5);
        offer_pattern(30'h2AAA_AAAA, 3'd0);
        offer_pattern(30'h1555_5555, 3'd1);
        offer_pattern(30'h2AAA_AAAA, 3'd7);
        offer_pattern(30'h1555_5555, 3'd6);
        offer_pattern('0, 3'd5);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd4);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd5);
        offer_pattern('0, 3'd7);
        offer_pattern(30'h3FFF_8000, 3'd2);
        offer_pattern(30'h0000_7FFF, 3'd3);
        offer_pattern({PIXEL_BITS{1'b1}}, 3'd0);

        // The sender holds back until the block has handed over every result.
        drain_results();

        for (int c = 0; c < DEF_NEURONS; c++)
            prototype[c] = PIXEL_BITS'($urandom());

        // Random part. It opens with a stretch of clean training epochs at full rate,
        // then mixes noisy training with mislabelled, out-of-range and raw patterns.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i < STEADY_ITEMS);
            pick = $urandom_range(99);
            cls  = $urandom_range(DEF_NEURONS - 1);
            if (steady) begin
                pix = prototype[i % DEF_NEURONS];
                tgt = TARGET_BITS'(i % DEF_NEURONS);
            end else if (pick < 70) begin
                pix = noisy_copy(cls);
                tgt = TARGET_BITS'(cls);
            end else if (pick < 78) begin
                pix = noisy_copy(cls);
                tgt = TARGET_BITS'($urandom_range(DEF_NEURONS - 1));
            end else if (pick < 84) begin
                pix = noisy_copy(cls);
                tgt = TARGET_BITS'($urandom_range(7, DEF_NEURONS));
            end else if (pick < 94) begin
                pix = PIXEL_BITS'($urandom());
                tgt = TARGET_BITS'($urandom_range(7));
            end else begin
                pix = ($urandom_range(1) == 1) ? {PIXEL_BITS{1'b1}} : '0;
                tgt = TARGET_BITS'($urandom_range(7));
            end
            offer_pattern(pix, tgt);
        end
        steady = 1'b0;

        drain_results();
        // Wait on afterwards, so that a stray result would still be caught.
        repeat (200) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("multiclass_perceptron_trainer test passed");
        else
            $display("multiclass_perceptron_trainer test failed");
        $finish;
    end

endmodule
